/* sv/mspm_pkg.sv */
`default_nettype none

package mspm_pkg;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_PATTERN = 2'd0,
      KIND_BUILD   = 2'd1,
      KIND_TEXT    = 2'd2,
      KIND_CLEAR   = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      RS_MATCH       = 3'd0,
      RS_STORED      = 3'd1,
      RS_REJECTED    = 3'd2,
      RS_BUILD_DONE  = 3'd3,
      RS_NOT_BUILT   = 3'd4,
      RS_CLEARED     = 3'd5
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_req;
      logic        last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  pattern_id;
      logic [31:0] start_pos;
      logic [31:0] end_pos;
      logic        final_res;
   } rsp_type;

   // At most this many match results are reported for one text byte.
   localparam int RESULT_CAP = 16;
   localparam int CNT_W      = 5;

   // ASCII letter range used by case folding.
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

`default_nettype wire

/* sv/mspm_node_store.sv */
`default_nettype none

module mspm_node_store #(
   parameter int MAX_NODES = 256,
   parameter int NODE_W    = 8,
   parameter int HEAD_W    = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [NODE_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_char,
   input  wire logic [NODE_W-1:0] wr_fail,
   input  wire logic [NODE_W-1:0] wr_first_child,
   input  wire logic [NODE_W-1:0] wr_sibling,
   input  wire logic [HEAD_W-1:0] wr_head,
   input  wire logic [NODE_W-1:0] rd_addr,
   output logic      [7:0]        rd_char,
   output logic      [NODE_W-1:0] rd_fail,
   output logic      [NODE_W-1:0] rd_first_child,
   output logic      [NODE_W-1:0] rd_sibling,
   output logic      [HEAD_W-1:0] rd_head
);

   typedef struct packed {
      logic [7:0]        ch;
      logic [NODE_W-1:0] fail;
      logic [NODE_W-1:0] first_child;
      logic [NODE_W-1:0] sibling;
      logic [HEAD_W-1:0] head;
   } node_rec_type;

   node_rec_type node_mem [MAX_NODES];
   node_rec_type rd_rec_ff;

   // One write port and one registered read port over the trie nodes.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= '{ch: wr_char, fail: wr_fail, first_child: wr_first_child,
                                sibling: wr_sibling, head: wr_head};
      end
      rd_rec_ff <= node_mem[rd_addr];
   end

   assign rd_char        = rd_rec_ff.ch;
   assign rd_fail        = rd_rec_ff.fail;
   assign rd_first_child = rd_rec_ff.first_child;
   assign rd_sibling     = rd_rec_ff.sibling;
   assign rd_head        = rd_rec_ff.head;

endmodule

`default_nettype wire

/* sv/multi_pattern_string_matcher.sv */
`default_nettype none

// Aho-Corasick multi-pattern matcher.
// Requests enter on req_data when start is high and busy is low. A pattern
// request appends one byte to the trie; its last byte gives a stored or
// rejected result. A build request computes failure links breadth-first and
// gives one result. A text request steps the automaton and gives one match
// result per pattern ending at that byte (at most 16), the last one flagged
// by final_res; a byte with no match gives no result. A clear request empties
// the trie. Results appear on rsp_data for one cycle under rsp_strobe; the
// receiver cannot stall. csr_we writes the fold_case bit; the user must write
// it only while idle, the block itself does not enforce this. One request
// runs at a time over the node memory, which has one write and one read port.
// A child search compares the children of a node one by one. A pattern byte
// runs that search and adds a node when none matches; a last byte walks the
// patterns already at the node. A text byte searches along failure links,
// then walks the output nodes and their results, then finishes. Clear and
// not-built text never raise busy. A build runs failure searches per node.
// Results are registered and come the cycle after the step that makes them.
// Reset empties the trie, sets fold_case and marks the automaton built.
module multi_pattern_string_matcher #(
   parameter int MAX_NODES       = 256,
   parameter int MAX_PATTERNS    = 16,
   parameter int MAX_PATTERN_LEN = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mspm_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output mspm_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata
);

   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int NCNT_W = NODE_W + 1;
   localparam int HEAD_W = $clog2(MAX_PATTERNS + 1);
   localparam int PIDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
   localparam logic [HEAD_W-1:0] NO_PAT = HEAD_W'(MAX_PATTERNS);

   typedef enum logic [26:0] {
      ST_IDLE      = 27'b1 << 0,
      ST_CH_HEAD   = 27'b1 << 1,
      ST_CH_HEAD_W = 27'b1 << 2,
      ST_CH_CMP    = 27'b1 << 3,
      ST_P_FOUND   = 27'b1 << 4,
      ST_P_LINK    = 27'b1 << 5,
      ST_P_END     = 27'b1 << 6,
      ST_P_HEAD_W  = 27'b1 << 7,
      ST_P_CHAIN   = 27'b1 << 8,
      ST_P_DONE    = 27'b1 << 9,
      ST_B_ROOT    = 27'b1 << 10,
      ST_B_ROOT_W  = 27'b1 << 11,
      ST_B_POP     = 27'b1 << 12,
      ST_B_POP_W   = 27'b1 << 13,
      ST_B_R_W     = 27'b1 << 14,
      ST_B_KID     = 27'b1 << 15,
      ST_B_KID_W   = 27'b1 << 16,
      ST_B_F       = 27'b1 << 17,
      ST_B_F_RET   = 27'b1 << 18,
      ST_B_FF_W    = 27'b1 << 19,
      ST_B_DONE    = 27'b1 << 20,
      ST_T_CHK     = 27'b1 << 21,
      ST_T_FW      = 27'b1 << 22,
      ST_T_OUT_N   = 27'b1 << 23,
      ST_T_OUT_W   = 27'b1 << 24,
      ST_T_PAT     = 27'b1 << 25,
      ST_T_FIN     = 27'b1 << 26
   } state_type;

   // Sequencer and automaton state.
   state_type                  state_ff, state_in, ret_ff, ret_in;
   logic                       fold_case_ff;
   logic [NCNT_W-1:0]          nc_ff, nc_in;
   logic [HEAD_W-1:0]          pcount_ff, pcount_in;
   logic                       built_ff, built_in;
   logic [NODE_W-1:0]          cursor_ff, cursor_in;
   logic [LEN_W-1:0]           ins_len_ff, ins_len_in;
   logic                       ins_fail_ff, ins_fail_in;
   logic [NODE_W-1:0]          match_ff, match_in;
   logic [31:0]                pos_ff, pos_in;
   logic [NODE_W-1:0]          root_fc_ff, root_fc_in;

   // Working registers of the current request.
   logic [7:0]                 c_ff, c_in;
   logic                       last_ff, last_in;
   logic [NODE_W-1:0]          n_ff, n_in, k_ff, k_in, found_ff, found_in;
   logic [7:0]                 par_char_ff, par_char_in;
   logic [NODE_W-1:0]          par_fail_ff, par_fail_in, par_fc_ff, par_fc_in;
   logic [NODE_W-1:0]          par_sib_ff, par_sib_in;
   logic [HEAD_W-1:0]          par_head_ff, par_head_in;
   logic [HEAD_W-1:0]          p_ff, p_in;
   logic [NODE_W-1:0]          qhead_ff, qhead_in, qtail_ff, qtail_in;
   logic [NODE_W-1:0]          bk_ff, bk_in, f_ff, f_in, rfail_ff, rfail_in;
   logic [NODE_W-1:0]          kr_fc_ff, kr_fc_in, kr_sib_ff, kr_sib_in;
   logic [HEAD_W-1:0]          kr_head_ff, kr_head_in;
   logic [NODE_W-1:0]          m_ff, m_in, mfail_ff, mfail_in;
   logic [mspm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       pend_v_ff, pend_v_in;
   mspm_pkg::rsp_type          pend_ff, pend_in;

   // Pattern tables.
   logic [LEN_W-1:0]           plen_ff  [MAX_PATTERNS];
   logic [HEAD_W-1:0]          pnext_ff [MAX_PATTERNS];
   logic                       plen_we, pnext_we, pnew_we;
   logic [PIDX_W-1:0]          pnext_idx;
   logic [HEAD_W-1:0]          pnext_val;

   // Output register.
   logic                       rsp_strobe_ff;
   mspm_pkg::rsp_type          rsp_data_ff;
   logic                       emit;
   mspm_pkg::rsp_type          emit_data;

   // Node memory ports.
   logic                       nw_en;
   logic [NODE_W-1:0]          nw_addr, nw_fail, nw_fc, nw_sib, raddr;
   logic [7:0]                 nw_char;
   logic [HEAD_W-1:0]          nw_head;
   logic [7:0]                 rd_char;
   logic [NODE_W-1:0]          rd_fail, rd_fc, rd_sib, eff_fc;
   logic [HEAD_W-1:0]          rd_head;
   logic                       rd_root_ff;

   // Breadth-first queue.
   logic [NODE_W-1:0]          bfs_mem [MAX_NODES];
   logic [NODE_W-1:0]          q_rdata_ff, q_raddr;
   logic                       q_we;

   // Helpers.
   logic [7:0]                 folded;
   logic [PIDX_W-1:0]          p_idx;
   logic [31:0]                len32, pos_p1, start_calc;
   mspm_pkg::rsp_type          match_rsp;

   mspm_node_store #(
      .MAX_NODES (MAX_NODES),
      .NODE_W    (NODE_W),
      .HEAD_W    (HEAD_W)
   ) u_nodes (
      .clock          (clock),
      .wr_en          (nw_en),
      .wr_addr        (nw_addr),
      .wr_char        (nw_char),
      .wr_fail        (nw_fail),
      .wr_first_child (nw_fc),
      .wr_sibling     (nw_sib),
      .wr_head        (nw_head),
      .rd_addr        (raddr),
      .rd_char        (rd_char),
      .rd_fail        (rd_fail),
      .rd_first_child (rd_fc),
      .rd_sibling     (rd_sib),
      .rd_head        (rd_head)
   );

   // The root's child list lives in a register so a clear is immediate.
   assign eff_fc = rd_root_ff ? root_fc_ff : rd_fc;

   // Case folding of the request byte.
   always_comb begin
      folded = req_data.byte_req;
      if (fold_case_ff && req_data.byte_req >= mspm_pkg::UPPER_FIRST &&
          req_data.byte_req <= mspm_pkg::UPPER_LAST) begin
         folded = req_data.byte_req + mspm_pkg::CASE_OFFSET;
      end
   end

   // Match result for pattern p ending at the current position.
   assign p_idx  = p_ff[PIDX_W-1:0];
   assign len32  = 32'(plen_ff[p_idx]);
   assign pos_p1 = pos_ff + 32'd1;
   assign start_calc = (len32 != 32'd0 && pos_p1 >= len32) ? pos_ff - (len32 - 32'd1) : 32'd0;

   always_comb begin
      match_rsp            = '0;
      match_rsp.status     = mspm_pkg::RS_MATCH;
      match_rsp.pattern_id = 4'(p_ff);
      match_rsp.start_pos  = start_calc;
      match_rsp.end_pos    = pos_ff;
      match_rsp.final_res  = 1'b0;
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;
      nc_in = nc_ff;         pcount_in = pcount_ff;   built_in = built_ff;
      cursor_in = cursor_ff; ins_len_in = ins_len_ff; ins_fail_in = ins_fail_ff;
      match_in = match_ff;   pos_in = pos_ff;         root_fc_in = root_fc_ff;
      c_in = c_ff;           last_in = last_ff;
      n_in = n_ff;           k_in = k_ff;             found_in = found_ff;
      par_char_in = par_char_ff; par_fail_in = par_fail_ff; par_fc_in = par_fc_ff;
      par_sib_in = par_sib_ff;   par_head_in = par_head_ff;
      p_in = p_ff;           qhead_in = qhead_ff;     qtail_in = qtail_ff;
      bk_in = bk_ff;         f_in = f_ff;             rfail_in = rfail_ff;
      kr_fc_in = kr_fc_ff;   kr_sib_in = kr_sib_ff;   kr_head_in = kr_head_ff;
      m_in = m_ff;           mfail_in = mfail_ff;     cnt_in = cnt_ff;
      pend_v_in = pend_v_ff; pend_in = pend_ff;
      plen_we = 1'b0; pnext_we = 1'b0; pnew_we = 1'b0;
      pnext_idx = p_idx; pnext_val = NO_PAT;
      emit = 1'b0; emit_data = '0;
      nw_en = 1'b0; nw_addr = '0; nw_char = c_ff; nw_fail = '0; nw_fc = '0;
      nw_sib = '0; nw_head = NO_PAT;
      raddr = '0; q_we = 1'b0; q_raddr = qhead_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               c_in    = folded;
               last_in = req_data.last;
               unique case (req_data.kind)
                  mspm_pkg::KIND_PATTERN: begin
                     built_in = 1'b0;
                     if (ins_fail_ff) begin
                        state_in = ST_P_END;
                     end else if (pcount_ff >= NO_PAT ||
                                  ins_len_ff >= LEN_W'(MAX_PATTERN_LEN)) begin
                        ins_fail_in = 1'b1;
                        state_in    = ST_P_END;
                     end else begin
                        n_in     = cursor_ff;
                        ret_in   = ST_P_FOUND;
                        state_in = ST_CH_HEAD;
                     end
                  end
                  mspm_pkg::KIND_BUILD: begin
                     bk_in    = root_fc_ff;
                     qhead_in = '0;
                     qtail_in = '0;
                     state_in = ST_B_ROOT;
                  end
                  mspm_pkg::KIND_TEXT: begin
                     if (!built_ff) begin
                        emit              = 1'b1;
                        emit_data.status  = mspm_pkg::RS_NOT_BUILT;
                        emit_data.end_pos = pos_ff;
                        emit_data.final_res = 1'b1;
                        if (req_data.last) begin
                           match_in = '0;
                           pos_in   = '0;
                        end
                     end else begin
                        n_in     = match_ff;
                        ret_in   = ST_T_CHK;
                        state_in = ST_CH_HEAD;
                     end
                  end
                  default: begin
                     nc_in       = NCNT_W'(1);
                     root_fc_in  = '0;
                     pcount_in   = '0;
                     built_in    = 1'b1;
                     cursor_in   = '0;
                     ins_len_in  = '0;
                     ins_fail_in = 1'b0;
                     match_in    = '0;
                     pos_in      = '0;
                     emit        = 1'b1;
                     emit_data.status    = mspm_pkg::RS_CLEARED;
                     emit_data.final_res = 1'b1;
                  end
               endcase
            end
         end

         // Child search: find the child of n_ff labelled c_ff.
         ST_CH_HEAD: begin
            raddr    = n_ff;
            state_in = ST_CH_HEAD_W;
         end
         ST_CH_HEAD_W: begin
            par_char_in = rd_char;
            par_fail_in = rd_fail;
            par_fc_in   = eff_fc;
            par_sib_in  = rd_sib;
            par_head_in = rd_head;
            if (eff_fc == '0) begin
               found_in = '0;
               state_in = ret_ff;
            end else begin
               raddr    = eff_fc;
               k_in     = eff_fc;
               state_in = ST_CH_CMP;
            end
         end
         ST_CH_CMP: begin
            if (rd_char == c_ff) begin
               found_in = k_ff;
               state_in = ret_ff;
            end else if (rd_sib == '0) begin
               found_in = '0;
               state_in = ret_ff;
            end else begin
               raddr = rd_sib;
               k_in  = rd_sib;
            end
         end

         // Pattern insertion.
         ST_P_FOUND: begin
            if (found_ff != '0) begin
               cursor_in  = found_ff;
               ins_len_in = ins_len_ff + LEN_W'(1);
               state_in   = ST_P_END;
            end else if (nc_ff < NCNT_W'(MAX_NODES)) begin
               nw_en    = 1'b1;
               nw_addr  = nc_ff[NODE_W-1:0];
               nw_sib   = par_fc_ff;
               state_in = ST_P_LINK;
            end else begin
               ins_fail_in = 1'b1;
               state_in    = ST_P_END;
            end
         end
         ST_P_LINK: begin
            if (cursor_ff == '0) begin
               root_fc_in = nc_ff[NODE_W-1:0];
            end else begin
               nw_en   = 1'b1;
               nw_addr = cursor_ff;
               nw_char = par_char_ff;
               nw_fail = par_fail_ff;
               nw_fc   = nc_ff[NODE_W-1:0];
               nw_sib  = par_sib_ff;
               nw_head = par_head_ff;
            end
            cursor_in  = nc_ff[NODE_W-1:0];
            nc_in      = nc_ff + NCNT_W'(1);
            ins_len_in = ins_len_ff + LEN_W'(1);
            state_in   = ST_P_END;
         end
         ST_P_END: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (ins_fail_ff || cursor_ff == '0 || pcount_ff >= NO_PAT) begin
               emit                = 1'b1;
               emit_data.status    = mspm_pkg::RS_REJECTED;
               emit_data.final_res = 1'b1;
               cursor_in   = '0;
               ins_len_in  = '0;
               ins_fail_in = 1'b0;
               state_in    = ST_IDLE;
            end else begin
               raddr    = cursor_ff;
               state_in = ST_P_HEAD_W;
            end
         end
         ST_P_HEAD_W: begin
            if (rd_head >= NO_PAT) begin
               nw_en    = 1'b1;
               nw_addr  = cursor_ff;
               nw_char  = rd_char;
               nw_fail  = rd_fail;
               nw_fc    = rd_fc;
               nw_sib   = rd_sib;
               nw_head  = pcount_ff;
               state_in = ST_P_DONE;
            end else begin
               p_in     = rd_head;
               state_in = ST_P_CHAIN;
            end
         end
         ST_P_CHAIN: begin
            if (pnext_ff[p_idx] < NO_PAT) begin
               p_in = pnext_ff[p_idx];
            end else begin
               pnext_we  = 1'b1;
               pnext_val = pcount_ff;
               state_in  = ST_P_DONE;
            end
         end
         ST_P_DONE: begin
            pnew_we   = 1'b1;
            pcount_in = pcount_ff + HEAD_W'(1);
            emit      = 1'b1;
            emit_data.status     = mspm_pkg::RS_STORED;
            emit_data.pattern_id = 4'(pcount_ff);
            emit_data.final_res  = 1'b1;
            cursor_in   = '0;
            ins_len_in  = '0;
            ins_fail_in = 1'b0;
            state_in    = ST_IDLE;
         end

         // Build: queue the root's children, then walk breadth-first.
         ST_B_ROOT: begin
            if (bk_ff == '0) begin
               state_in = ST_B_POP;
            end else begin
               raddr    = bk_ff;
               state_in = ST_B_ROOT_W;
            end
         end
         ST_B_ROOT_W: begin
            q_we     = 1'b1;
            qtail_in = qtail_ff + NODE_W'(1);
            bk_in    = rd_sib;
            state_in = ST_B_ROOT;
         end
         ST_B_POP: begin
            if (qhead_ff == qtail_ff) begin
               state_in = ST_B_DONE;
            end else begin
               q_raddr  = qhead_ff;
               qhead_in = qhead_ff + NODE_W'(1);
               state_in = ST_B_POP_W;
            end
         end
         ST_B_POP_W: begin
            raddr    = q_rdata_ff;
            state_in = ST_B_R_W;
         end
         ST_B_R_W: begin
            rfail_in = rd_fail;
            bk_in    = rd_fc;
            state_in = ST_B_KID;
         end
         ST_B_KID: begin
            if (bk_ff == '0) begin
               state_in = ST_B_POP;
            end else begin
               raddr    = bk_ff;
               state_in = ST_B_KID_W;
            end
         end
         ST_B_KID_W: begin
            q_we       = 1'b1;
            qtail_in   = qtail_ff + NODE_W'(1);
            c_in       = rd_char;
            kr_fc_in   = rd_fc;
            kr_sib_in  = rd_sib;
            kr_head_in = rd_head;
            f_in       = rfail_ff;
            state_in   = ST_B_F;
         end
         ST_B_F: begin
            n_in     = f_ff;
            ret_in   = ST_B_F_RET;
            state_in = ST_CH_HEAD;
         end
         ST_B_F_RET: begin
            if (found_ff != '0 || f_ff == '0) begin
               nw_en    = 1'b1;
               nw_addr  = bk_ff;
               nw_fail  = found_ff;
               nw_fc    = kr_fc_ff;
               nw_sib   = kr_sib_ff;
               nw_head  = kr_head_ff;
               bk_in    = kr_sib_ff;
               state_in = ST_B_KID;
            end else begin
               raddr    = f_ff;
               state_in = ST_B_FF_W;
            end
         end
         ST_B_FF_W: begin
            f_in     = rd_fail;
            state_in = ST_B_F;
         end
         ST_B_DONE: begin
            built_in = 1'b1;
            match_in = '0;
            pos_in   = '0;
            emit     = 1'b1;
            emit_data.status    = mspm_pkg::RS_BUILD_DONE;
            emit_data.final_res = 1'b1;
            state_in = ST_IDLE;
         end

         // Text: follow failure links until a child matches or the root is hit.
         ST_T_CHK: begin
            if (found_ff != '0 || n_ff == '0) begin
               match_in = found_ff;
               m_in     = found_ff;
               cnt_in   = '0;
               state_in = ST_T_OUT_N;
            end else begin
               raddr    = n_ff;
               state_in = ST_T_FW;
            end
         end
         ST_T_FW: begin
            n_in     = rd_fail;
            ret_in   = ST_T_CHK;
            state_in = ST_CH_HEAD;
         end
         ST_T_OUT_N: begin
            if (m_ff == '0 || cnt_ff == mspm_pkg::CNT_W'(mspm_pkg::RESULT_CAP)) begin
               state_in = ST_T_FIN;
            end else begin
               raddr    = m_ff;
               state_in = ST_T_OUT_W;
            end
         end
         ST_T_OUT_W: begin
            p_in     = rd_head;
            mfail_in = rd_fail;
            state_in = ST_T_PAT;
         end
         ST_T_PAT: begin
            if (p_ff < NO_PAT && cnt_ff < mspm_pkg::CNT_W'(mspm_pkg::RESULT_CAP)) begin
               // Hold each result back one step so the last can be flagged.
               emit      = pend_v_ff;
               emit_data = pend_ff;
               pend_in   = match_rsp;
               pend_v_in = 1'b1;
               cnt_in    = cnt_ff + mspm_pkg::CNT_W'(1);
               p_in      = pnext_ff[p_idx];
            end else begin
               m_in     = mfail_ff;
               state_in = ST_T_OUT_N;
            end
         end
         ST_T_FIN: begin
            emit      = pend_v_ff;
            emit_data = pend_ff;
            emit_data.final_res = 1'b1;
            pend_v_in = 1'b0;
            if (pos_ff != 32'hFFFF_FFFF) begin
               pos_in = pos_p1;
            end
            if (last_ff) begin
               match_in = '0;
               pos_in   = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         fold_case_ff  <= 1'b1;
         nc_ff         <= NCNT_W'(1);
         pcount_ff     <= '0;
         built_ff      <= 1'b1;
         cursor_ff     <= '0;
         ins_len_ff    <= '0;
         ins_fail_ff   <= 1'b0;
         match_ff      <= '0;
         pos_ff        <= '0;
         root_fc_ff    <= '0;
         pend_v_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         if (csr_we) begin
            fold_case_ff <= csr_wdata;
         end
         nc_ff         <= nc_in;
         pcount_ff     <= pcount_in;
         built_ff      <= built_in;
         cursor_ff     <= cursor_in;
         ins_len_ff    <= ins_len_in;
         ins_fail_ff   <= ins_fail_in;
         match_ff      <= match_in;
         pos_ff        <= pos_in;
         root_fc_ff    <= root_fc_in;
         pend_v_ff     <= pend_v_in;
         rsp_strobe_ff <= emit;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      c_ff        <= c_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      found_ff    <= found_in;
      par_char_ff <= par_char_in;
      par_fail_ff <= par_fail_in;
      par_fc_ff   <= par_fc_in;
      par_sib_ff  <= par_sib_in;
      par_head_ff <= par_head_in;
      p_ff        <= p_in;
      qhead_ff    <= qhead_in;
      qtail_ff    <= qtail_in;
      bk_ff       <= bk_in;
      f_ff        <= f_in;
      rfail_ff    <= rfail_in;
      kr_fc_ff    <= kr_fc_in;
      kr_sib_ff   <= kr_sib_in;
      kr_head_ff  <= kr_head_in;
      m_ff        <= m_in;
      mfail_ff    <= mfail_in;
      cnt_ff      <= cnt_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= emit_data;
      rd_root_ff  <= (raddr == '0);
   end

   // Pattern tables.
   always_ff @(posedge clock) begin
      if (pnext_we) begin
         pnext_ff[pnext_idx] <= pnext_val;
      end
      if (pnew_we) begin
         plen_ff[pcount_ff[PIDX_W-1:0]]  <= ins_len_ff;
         pnext_ff[pcount_ff[PIDX_W-1:0]] <= NO_PAT;
      end
   end

   // Breadth-first queue memory.
   always_ff @(posedge clock) begin
      if (q_we) begin
         bfs_mem[qtail_ff] <= bk_ff;
      end
      q_rdata_ff <= bfs_mem[q_raddr];
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_clear_result : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == mspm_pkg::KIND_CLEAR |=>
      rsp_strobe && rsp_data.status == mspm_pkg::RS_CLEARED && rsp_data.final_res)
      else $error("clear request gave no cleared result");

   a_single_final : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != mspm_pkg::RS_MATCH |-> rsp_data.final_res)
      else $error("non-match result without final flag");

   a_node_count : assert property (@(posedge clock) disable iff (reset)
      nc_ff >= NCNT_W'(1) && nc_ff <= NCNT_W'(MAX_NODES))
      else $error("node count out of range");

   a_pattern_count : assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= NO_PAT)
      else $error("pattern count out of range");
`endif

endmodule

`default_nettype wire

/* test/mspm_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register ports of the matcher, keeps its
// own copy of the trie and automaton, and compares every result it sees.
module mspm_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire mspm_pkg::req_type req_data,
   input  wire logic              rsp_strobe,
   input  wire mspm_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam int NODES     = 256;
   localparam int PATTERNS  = 16;
   localparam int PAT_LEN   = 32;
   localparam int EXP_DEPTH = 64;
   localparam logic [4:0] NO_PAT = 5'd16;

   logic [7:0]  node_char [NODES];
   logic [7:0]  node_fail [NODES];
   logic [7:0]  node_child [NODES];
   logic [7:0]  node_sib [NODES];
   logic [4:0]  node_pat [NODES];
   logic [5:0]  pat_len [PATTERNS];
   logic [4:0]  pat_next [PATTERNS];
   logic [8:0]  node_count;
   logic [4:0]  pat_count;
   logic        built;
   logic [7:0]  cursor;
   logic [5:0]  cursor_len;
   logic        insert_bad;
   logic [7:0]  state_node;
   logic [31:0] text_pos;
   logic        fold_case;

   // Expected results in order, as a ring buffer.
   mspm_pkg::rsp_type exp_mem [EXP_DEPTH];
   int                exp_wr = 0;
   int                exp_rd = 0;

   assign pending = exp_wr - exp_rd;

   function automatic void expect_rsp(mspm_pkg::status_type st, logic [3:0] id,
                                      logic [31:0] sp, logic [31:0] ep, logic fin);
      mspm_pkg::rsp_type r;
      r.status = st;
      r.pattern_id = id;
      r.start_pos = sp;
      r.end_pos = ep;
      r.final_res = fin;
      exp_mem[exp_wr[5:0]] = r;
      exp_wr++;
   endfunction

   function automatic logic [7:0] child_of(logic [7:0] n, logic [7:0] c);
      logic [7:0] k;
      int guard;
      if (n >= node_count) return 8'd0;
      k = node_child[n];
      for (guard = 0; k != 0 && k < node_count && guard < NODES; guard++) begin
         if (node_char[k] == c) return k;
         k = node_sib[k];
      end
      return 8'd0;
   endfunction

   function automatic logic [7:0] fail_of(logic [7:0] n);
      return (node_fail[n] < node_count) ? node_fail[n] : 8'd0;
   endfunction

   function automatic void clear_trie();
      node_count = 9'd1;
      node_child[0] = 0;
      node_sib[0] = 0;
      node_fail[0] = 0;
      node_char[0] = 0;
      node_pat[0] = NO_PAT;
      pat_count = 0;
      built = 1'b1;
      cursor = 0;
      cursor_len = 0;
      insert_bad = 1'b0;
      state_node = 0;
      text_pos = 0;
   endfunction

   // Breadth-first pass that sets the failure link of every node.
   function automatic void build_links();
      logic [7:0] order [NODES];
      int head, tail, guard;
      logic [7:0] k, r, f;
      head = 0;
      tail = 0;
      for (k = node_child[0]; k != 0 && k < node_count && tail < NODES; k = node_sib[k]) begin
         node_fail[k] = 0;
         order[tail++] = k;
      end
      while (head < tail) begin
         r = order[head++];
         for (k = node_child[r]; k != 0 && k < node_count && tail < NODES;
              k = node_sib[k]) begin
            order[tail++] = k;
            f = node_fail[r];
            for (guard = 0; guard < NODES && f != 0 && child_of(f, node_char[k]) == 0;
                 guard++)
               f = fail_of(f);
            node_fail[k] = child_of(f, node_char[k]);
         end
      end
      built = 1'b1;
      state_node = 0;
      text_pos = 0;
   endfunction

   function automatic void add_pattern_byte(logic [7:0] c, logic last);
      logic [7:0] nxt;
      logic [4:0] p;
      int guard;
      built = 1'b0;
      if (!insert_bad) begin
         if (pat_count >= PATTERNS || cursor_len >= PAT_LEN) begin
            insert_bad = 1'b1;
         end else begin
            nxt = child_of(cursor, c);
            if (nxt == 0) begin
               if (node_count < NODES) begin
                  nxt = node_count[7:0];
                  node_count++;
                  node_char[nxt] = c;
                  node_fail[nxt] = 0;
                  node_child[nxt] = 0;
                  node_pat[nxt] = NO_PAT;
                  node_sib[nxt] = node_child[cursor];
                  node_child[cursor] = nxt;
               end else begin
                  insert_bad = 1'b1;
               end
            end
            if (!insert_bad) begin
               cursor = nxt;
               cursor_len++;
            end
         end
      end
      if (!last) return;
      if (insert_bad || cursor == 0 || pat_count >= PATTERNS) begin
         expect_rsp(mspm_pkg::RS_REJECTED, 4'd0, 32'd0, 32'd0, 1'b1);
      end else begin
         pat_len[pat_count[3:0]] = cursor_len;
         pat_next[pat_count[3:0]] = NO_PAT;
         if (node_pat[cursor] >= NO_PAT) begin
            node_pat[cursor] = pat_count;
         end else begin
            p = node_pat[cursor];
            for (guard = 0; guard < PATTERNS && pat_next[p[3:0]] < NO_PAT; guard++)
               p = pat_next[p[3:0]];
            pat_next[p[3:0]] = pat_count;
         end
         expect_rsp(mspm_pkg::RS_STORED, pat_count[3:0], 32'd0, 32'd0, 1'b1);
         pat_count++;
      end
      cursor = 0;
      cursor_len = 0;
      insert_bad = 1'b0;
   endfunction

   // One automaton step; reports the patterns at the reached node, then
   // those along its failure chain.
   function automatic void scan_text_byte(logic [7:0] c, logic last);
      logic [7:0] n;
      logic [4:0] p;
      logic [32:0] len;
      logic [5:0] tail_idx;
      int guard, pg, cnt;
      cnt = 0;
      if (!built) begin
         expect_rsp(mspm_pkg::RS_NOT_BUILT, 4'd0, 32'd0, text_pos, 1'b1);
      end else begin
         n = (state_node < node_count) ? state_node : 8'd0;
         for (guard = 0; guard < NODES && n != 0 && child_of(n, c) == 0; guard++)
            n = fail_of(n);
         n = child_of(n, c);
         state_node = n;
         for (guard = 0; n != 0 && guard < NODES && cnt < mspm_pkg::RESULT_CAP;
              guard++) begin
            p = node_pat[n];
            for (pg = 0; p < NO_PAT && pg < PATTERNS && cnt < mspm_pkg::RESULT_CAP;
                 pg++) begin
               len = {27'd0, pat_len[p[3:0]]};
               expect_rsp(mspm_pkg::RS_MATCH, p[3:0],
                          (len != 0 && {1'b0, text_pos} + 1 >= len) ?
                             text_pos - (len[31:0] - 1) : 32'd0,
                          text_pos, 1'b0);
               cnt++;
               p = pat_next[p[3:0]];
            end
            n = fail_of(n);
         end
         if (cnt > 0) begin
            tail_idx = 6'(exp_wr - 1);
            exp_mem[tail_idx].final_res = 1'b1;
         end
         if (text_pos != 32'hFFFF_FFFF) text_pos++;
      end
      if (last) begin
         state_node = 0;
         text_pos = 0;
      end
   endfunction

   always @(posedge clock) begin
      mspm_pkg::rsp_type got;
      logic [7:0] c;
      if (reset) begin
         fold_case = 1'b1;
         clear_trie();
         exp_rd = exp_wr;
         fail_count = 0;
      end else begin
         // Compare a result against the oldest expectation.
         if (rsp_strobe) begin
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %p", rsp_data);
            end else begin
               got = exp_mem[exp_rd[5:0]];
               exp_rd++;
               if (got != rsp_data) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected %p, got %p", got, rsp_data);
               end
            end
         end
         if (csr_we) fold_case = csr_wdata;
         // Predict the results of an accepted request.
         if (start && !busy) begin
            c = req_data.byte_req;
            if (fold_case && c >= mspm_pkg::UPPER_FIRST && c <= mspm_pkg::UPPER_LAST)
               c = c + mspm_pkg::CASE_OFFSET;
            case (req_data.kind)
               mspm_pkg::KIND_PATTERN: add_pattern_byte(c, req_data.last);
               mspm_pkg::KIND_BUILD: begin
                  build_links();
                  expect_rsp(mspm_pkg::RS_BUILD_DONE, 4'd0, 32'd0, 32'd0, 1'b1);
               end
               mspm_pkg::KIND_TEXT: scan_text_byte(c, req_data.last);
               default: begin
                  clear_trie();
                  expect_rsp(mspm_pkg::RS_CLEARED, 4'd0, 32'd0, 32'd0, 1'b1);
               end
            endcase
         end
      end
   end
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   mspm_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   mspm_pkg::rsp_type rsp_data;
   logic              csr_we = 1'b0;
   logic              csr_wdata = 1'b0;
   int                fail_count;
   int                pending;
   int                cycle_count = 0;
   int                random_requests = 0;
   bit                steady = 1'b0;

   always #10 clock = ~clock;

   multi_pattern_string_matcher u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   mspm_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_wdata(csr_wdata), .fail_count(fail_count), .pending(pending)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Issue one request and return at the edge that accepts it. The start
   // line stays high into the next request unless an idle gap is taken.
   task automatic send(mspm_pkg::kind_type kind, logic [7:0] b, logic last);
      if (!steady && $urandom_range(99) < 28) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      start <= 1'b1;
      req_data <= '{kind: kind, byte_req: b, last: last};
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_string(mspm_pkg::kind_type kind, string s);
      for (int i = 0; i < s.len(); i++)
         send(kind, s[i], i == s.len() - 1);
   endtask

   // Wait until every expected result has come and the block is idle.
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_fold(logic v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] letters [4] = '{8'h61, 8'h62, 8'h41, 8'h42};
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return letters[$urandom_range(3)];
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty automaton, classic pattern set, duplicate pattern,
      // extreme byte values, text before build, clear.
      send_string(mspm_pkg::KIND_TEXT, "x");
      send_string(mspm_pkg::KIND_PATTERN, "He");
      send_string(mspm_pkg::KIND_PATTERN, "SHE");
      send_string(mspm_pkg::KIND_PATTERN, "his");
      send_string(mspm_pkg::KIND_PATTERN, "hers");
      send_string(mspm_pkg::KIND_PATTERN, "he");
      send(mspm_pkg::KIND_PATTERN, 8'h00, 1'b0);
      send(mspm_pkg::KIND_PATTERN, 8'hFF, 1'b1);
      send(mspm_pkg::KIND_TEXT, 8'h61, 1'b0);
      send(mspm_pkg::KIND_BUILD, 8'hFF, 1'b1);
      send_string(mspm_pkg::KIND_TEXT, "uSHErs");
      send(mspm_pkg::KIND_TEXT, 8'h00, 1'b0);
      send(mspm_pkg::KIND_TEXT, 8'hFF, 1'b1);
      send(mspm_pkg::KIND_CLEAR, 8'h00, 1'b0);

      // Sixteen copies of one pattern fill the table and give sixteen
      // results at once; a seventeenth is rejected. Case folding off.
      write_fold(1'b0);
      for (int n = 0; n < 16; n++) send(mspm_pkg::KIND_PATTERN, 8'h61, 1'b1);
      send_string(mspm_pkg::KIND_PATTERN, "A");
      send(mspm_pkg::KIND_BUILD, 8'h00, 1'b0);
      send_string(mspm_pkg::KIND_TEXT, "aAa");

      // Pattern longer than the limit, then a short one that matches.
      send(mspm_pkg::KIND_CLEAR, 8'h00, 1'b1);
      for (int i = 0; i < 33; i++) send(mspm_pkg::KIND_PATTERN, 8'h7A, i == 32);
      send_string(mspm_pkg::KIND_PATTERN, "zz");
      send(mspm_pkg::KIND_BUILD, 8'h00, 1'b0);
      send_string(mspm_pkg::KIND_TEXT, "zzz");

      // Random phases: short patterns over a small alphabet, a build, text.
      while (random_requests < 185) begin
         if ($urandom_range(3) == 0) write_fold(1'($urandom_range(1)));
         steady = (random_requests > 60 && random_requests < 120);
         if ($urandom_range(2) != 0) begin
            send(mspm_pkg::KIND_CLEAR, pick_byte(), 1'($urandom_range(1)));
            random_requests++;
         end
         repeat ($urandom_range(6, 1)) begin
            int len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
               send(mspm_pkg::KIND_PATTERN, pick_byte(), i == len - 1);
               random_requests++;
            end
         end
         // Occasionally text arrives before the build.
         if ($urandom_range(9) == 0) begin
            send(mspm_pkg::KIND_TEXT, pick_byte(), 1'($urandom_range(1)));
            random_requests++;
         end
         send(mspm_pkg::KIND_BUILD, pick_byte(), 1'($urandom_range(1)));
         random_requests++;
         repeat ($urandom_range(30, 10)) begin
            if ($urandom_range(19) == 0)
               send(mspm_pkg::kind_type'($urandom_range(3)), pick_byte(),
                    1'($urandom_range(1)));
            else
               send(mspm_pkg::KIND_TEXT, pick_byte(), $urandom_range(7) == 0);
            random_requests++;
         end
      end
      steady = 1'b0;
      write_fold(1'b1);

      wait_idle();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

/* files.f */
sv/mspm_pkg.sv
sv/mspm_node_store.sv
sv/multi_pattern_string_matcher.sv
test/mspm_checker.sv
test/tb_top.sv
